### rtl/rpn_pkg.sv
// Package for the postfix calculator stack: word types, opcodes, status codes
// and sizing constants. No dependencies.
package rpn_pkg;

    localparam int StackDepth = 64;
    localparam int PtrW = $clog2(StackDepth);
    localparam int CntW = $clog2(StackDepth + 1);

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5
    } opcode_t;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_DIVZ  = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    localparam logic signed [31:0] MinusOneQ = 32'shFFFF0000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
        logic [6:0]         height;
        logic               empty_res;
    } out_word_t;

    typedef struct packed {
        logic               start;
        logic signed [47:0] dividend;
        logic signed [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [48:0] quotient;
    } div_rsp_t;

endpackage

### rtl/rpn_divider.sv
// Radix-2 restoring divider for the calculator: signed 48 by 32 bits,
// quotient truncated toward zero. Depends on rpn_pkg.
module rpn_divider
(
    input  logic             clk,
    input  logic             rst_n,
    input  rpn_pkg::div_req_t req,
    output rpn_pkg::div_rsp_t rsp
);

    logic [47:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [48:0] q_mag;

    assign trial = {rem_reg, num_reg[47]} - {2'b00, den_reg};
    assign q_mag = {1'b0, num_reg};

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = req.dividend[47] ? 48'(-req.dividend) : 48'(req.dividend);
            den_next  = req.divisor[31] ? 32'(-req.divisor) : 32'(req.divisor);
            neg_next  = req.dividend[47] ^ req.divisor[31];
            rem_next  = '0;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Shift in one dividend bit; quotient bits fill num from the bottom.
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                num_next = {num_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], num_reg[47]};
                num_next = {num_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -q_mag : q_mag;

endmodule

### rtl/rpn_stack_ram.sv
// Stack storage for the calculator: one write port and one registered read port.
// Depends on rpn_pkg.
module rpn_stack_ram
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [rpn_pkg::PtrW-1:0] waddr,
    input  logic signed [31:0]       wdata,
    input  logic [rpn_pkg::PtrW-1:0] raddr,
    output logic signed [31:0]       rdata
);

    logic signed [31:0] mem [rpn_pkg::StackDepth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/rpn_stack_calculator_core.sv
// Postfix calculator stack, signed Q16.16, top level. Depends on rpn_pkg,
// rpn_stack_ram and rpn_divider.
// Push, unknown opcodes, full, empty pop and underflow answer straight from S_IDLE; pop
// and divide by zero read the stack in S_RDA and S_RDB; add/sub go on to S_EXEC, multiply
// to S_MUL and S_EXEC, divide to S_DIV for the 48 steps of the radix-2 divider and S_EXEC.
// One word is in work at a time; the next can be accepted in the cycle after the result leaves.
// Reset clears the height to zero; stack contents are undefined until written.
module rpn_stack_calculator_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rpn_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rpn_pkg::out_word_t out_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RDA   = 7'b0000010,
        S_RDB   = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    localparam int CW = rpn_pkg::CntW;
    localparam int PW = rpn_pkg::PtrW;

    state_t state_reg, state_next;
    logic [CW-1:0] hgt_reg, hgt_next;
    logic [2:0] op_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_hold_reg;
    logic signed [63:0] prod_reg;
    logic out_valid_reg;
    rpn_pkg::out_word_t out_reg, out_next;
    logic out_load;

    logic we;
    logic [PW-1:0] waddr, raddr;
    logic signed [31:0] wdata, rdata;
    rpn_pkg::div_req_t dreq;
    rpn_pkg::div_rsp_t drsp;

    logic accept;
    logic signed [33:0] sum;
    logic signed [63:0] r64;
    logic signed [31:0] clamped;
    logic sat;

    rpn_stack_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                         .raddr(raddr), .rdata(rdata));
    rpn_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        sum = '0;
        r64 = '0;
        if (op_reg == rpn_pkg::OP_ADD)
        begin
            sum = 34'(b_hold_reg) + 34'(a_reg);
            r64 = 64'(sum);
        end
        else if (op_reg == rpn_pkg::OP_SUB)
        begin
            sum = 34'(b_hold_reg) - 34'(a_reg);
            r64 = 64'(sum);
        end
        else if (op_reg == rpn_pkg::OP_MUL)
        begin
            r64 = prod_reg >>> 16;
        end
        else
        begin
            r64 = 64'(drsp.quotient);
        end
        sat = 1'b0;
        clamped = r64[31:0];
        if (r64 > 64'sd2147483647)
        begin
            sat = 1'b1;
            clamped = 32'sh7FFFFFFF;
        end
        else if (r64 < -64'sd2147483648)
        begin
            sat = 1'b1;
            clamped = 32'sh80000000;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hgt_next   = hgt_reg;
        out_next   = out_reg;
        out_load   = 1'b0;
        we         = 1'b0;
        waddr      = hgt_reg[PW-1:0];
        wdata      = in_data.operand;
        raddr      = PW'(hgt_reg - CW'(1));
        dreq.start    = 1'b0;
        dreq.dividend = {rdata, 16'h0000};
        dreq.divisor  = a_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next.value  = '0;
                    out_next.status = rpn_pkg::ST_OK;
                    state_next = S_OUT;
                    out_load = 1'b1;
                    case (in_data.opcode)
                        rpn_pkg::OP_PUSH:
                        begin
                            if (hgt_reg >= CW'(rpn_pkg::StackDepth))
                            begin
                                out_next.status = rpn_pkg::ST_FULL;
                            end
                            else
                            begin
                                we = 1'b1;
                                hgt_next = hgt_reg + CW'(1);
                                out_next.value = in_data.operand;
                            end
                        end
                        rpn_pkg::OP_POP:
                        begin
                            if (hgt_reg == '0)
                            begin
                                out_next.value  = rpn_pkg::MinusOneQ;
                                out_next.status = rpn_pkg::ST_UNDER;
                            end
                            else
                            begin
                                out_load = 1'b0;
                                state_next = S_RDA;
                            end
                        end
                        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB,
                        rpn_pkg::OP_MUL, rpn_pkg::OP_DIV:
                        begin
                            if (hgt_reg < CW'(2))
                            begin
                                out_next.status = rpn_pkg::ST_UNDER;
                            end
                            else
                            begin
                                out_load = 1'b0;
                                state_next = S_RDA;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_next.height    = 7'(hgt_next);
                    out_next.empty_res = (hgt_next == '0);
                end
            end
            S_RDA:
            begin
                // The top entry is in rdata now; launch the read of the one below.
                raddr = PW'(hgt_reg - CW'(2));
                if (op_reg == rpn_pkg::OP_POP)
                begin
                    state_next = S_RDB;
                end
                else
                begin
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                if (op_reg == rpn_pkg::OP_POP)
                begin
                    hgt_next = hgt_reg - CW'(1);
                    out_next.value  = a_reg;
                    out_next.status = rpn_pkg::ST_OK;
                    out_next.height = 7'(hgt_next);
                    out_next.empty_res = (hgt_next == '0);
                    out_load = 1'b1;
                    state_next = S_OUT;
                end
                else if (op_reg == rpn_pkg::OP_MUL)
                begin
                    state_next = S_MUL;
                end
                else if (op_reg == rpn_pkg::OP_DIV)
                begin
                    if (a_reg == '0)
                    begin
                        hgt_next = hgt_reg - CW'(2);
                        out_next.value  = '0;
                        out_next.status = rpn_pkg::ST_DIVZ;
                        out_next.height = 7'(hgt_next);
                        out_next.empty_res = (hgt_next == '0);
                        out_load = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        dreq.start = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_MUL:
            begin
                state_next = S_EXEC;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                hgt_next = hgt_reg - CW'(1);
                we    = 1'b1;
                waddr = PW'(hgt_reg - CW'(2));
                wdata = clamped;
                out_next.value  = clamped;
                out_next.status = sat ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                out_next.height = 7'(hgt_next);
                out_next.empty_res = (hgt_next == '0);
                out_load = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hgt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hgt_reg   <= hgt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The read port moves back to the top after S_RDB, so b is kept in a register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= in_data.opcode;
        end
        if (state_reg == S_RDA)
        begin
            a_reg <= rdata;
        end
        if (state_reg == S_RDB)
        begin
            b_hold_reg <= rdata;
            prod_reg   <= 64'(rdata) * 64'(a_reg);
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result word changed while waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        hgt_reg <= CW'(rpn_pkg::StackDepth))
        else $error("stack height beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide");

endmodule

### tb/tb_rpn_stack_calculator_core.sv
// Self-checking testbench for the postfix calculator stack core.
// Depends on rpn_pkg and the rpn_stack_calculator_core RTL; drives words through
// valid/ready and checks every result word against a behavioral stack model.
module tb_rpn_stack_calculator_core;

    // Opcodes outside the defined set; the core answers them with value zero and status OK.
    localparam logic [2:0] OpSpare6 = 3'd6;
    localparam logic [2:0] OpSpare7 = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    rpn_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    rpn_pkg::out_word_t out_data;

    rpn_stack_calculator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Model state of the stack.
    logic signed [31:0] calc_stack [rpn_pkg::StackDepth];
    int                 calc_height;

    rpn_pkg::out_word_t result_queue [$];
    int        error_count;
    int        result_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        op_count [8];

    // One row of the directed table; check_exp marks rows with a typed-in result.
    typedef struct {
        logic [2:0]         opcode;
        logic signed [31:0] operand;
        logic               check_exp;
        rpn_pkg::out_word_t exp_word;
    } dir_row_t;

    dir_row_t dir_table [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v, ref logic sat);
        if (v > 66'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -66'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic rpn_pkg::out_word_t calc_step(input rpn_pkg::in_word_t w);
        rpn_pkg::out_word_t r;
        logic signed [65:0] a;
        logic signed [65:0] b;
        logic signed [65:0] acc;
        logic               sat;
        r = '0;
        r.status = rpn_pkg::ST_OK;
        sat = 1'b0;
        if (w.opcode == rpn_pkg::OP_PUSH)
        begin
            if (calc_height >= rpn_pkg::StackDepth)
                r.status = rpn_pkg::ST_FULL;
            else
            begin
                calc_stack[calc_height] = w.operand;
                calc_height++;
                r.value = w.operand;
            end
        end
        else if (w.opcode == rpn_pkg::OP_POP)
        begin
            if (calc_height == 0)
            begin
                r.value = rpn_pkg::MinusOneQ;
                r.status = rpn_pkg::ST_UNDER;
            end
            else
            begin
                calc_height--;
                r.value = calc_stack[calc_height];
            end
        end
        else if (w.opcode <= rpn_pkg::OP_DIV)
        begin
            if (calc_height < 2)
                r.status = rpn_pkg::ST_UNDER;
            else
            begin
                a = calc_stack[calc_height-1];
                b = calc_stack[calc_height-2];
                calc_height -= 2;
                if (w.opcode == rpn_pkg::OP_DIV && a == 0)
                    r.status = rpn_pkg::ST_DIVZ;
                else
                begin
                    case (w.opcode)
                        rpn_pkg::OP_ADD: acc = b + a;
                        rpn_pkg::OP_SUB: acc = b - a;
                        rpn_pkg::OP_MUL: acc = (b * a) >>> 16;
                        default:         acc = (b * 66'sd65536) / a;
                    endcase
                    r.value = sat32(acc, sat);
                    calc_stack[calc_height] = r.value;
                    calc_height++;
                    if (sat)
                        r.status = rpn_pkg::ST_SAT;
                end
            end
        end
        r.height = calc_height[6:0];
        r.empty_res = (calc_height == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
        error_count++;
    endtask

    // Valid stays high after acceptance unless the sender idles or stops.
    task automatic send_word(input rpn_pkg::in_word_t w, input logic check_exp,
                             input rpn_pkg::out_word_t typed);
        rpn_pkg::out_word_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pred = calc_step(w);
        if (check_exp && pred != typed)
            report_mismatch("typed row vs model", pred[42:11], typed[42:11]);
        result_queue.push_back(check_exp ? typed : pred);
        op_count[w.opcode]++;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Result side: random stalls, compare against the oldest expectation.
    always @(posedge clk)
    begin
        rpn_pkg::out_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    report_mismatch("unexpected word", out_data.value, 32'd0);
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (out_data.value !== want.value)
                        report_mismatch("value", out_data.value, want.value);
                    if (out_data.status !== want.status)
                        report_mismatch("status", 32'(out_data.status), 32'(want.status));
                    if (out_data.height !== want.height)
                        report_mismatch("height", 32'(out_data.height), 32'(want.height));
                    if (out_data.empty_res !== want.empty_res)
                        report_mismatch("empty_res", 32'(out_data.empty_res),
                                        32'(want.empty_res));
                end
                result_count++;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(5))
            0:       return $urandom_range(7) << 16;
            1:       return -($urandom_range(7) << 16);
            2:       return 32'sh7FFFFFFF;
            3:       return 32'sh80000000;
            4:       return 0;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [2:0] op, input logic signed [31:0] opnd,
                           input logic chk, input logic signed [31:0] v,
                           input logic [2:0] st, input int h);
        dir_row_t row;
        row.opcode = op;
        row.operand = opnd;
        row.check_exp = chk;
        row.exp_word.value = v;
        row.exp_word.status = st;
        row.exp_word.height = h[6:0];
        row.exp_word.empty_res = (h == 0);
        dir_table.push_back(row);
    endtask

    initial
    begin
        rpn_pkg::in_word_t w;
        int       phase;
        int       n;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        result_count = 0;
        calc_height = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (op_count[i])
            op_count[i] = 0;

        add_row(rpn_pkg::OP_POP,  32'sd0, 1'b1, rpn_pkg::MinusOneQ, rpn_pkg::ST_UNDER, 0);
        add_row(rpn_pkg::OP_ADD,  32'sd0, 1'b1, 32'sd0, rpn_pkg::ST_UNDER, 0);
        add_row(rpn_pkg::OP_PUSH, 32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF, rpn_pkg::ST_OK, 1);
        add_row(rpn_pkg::OP_MUL,  32'sd0, 1'b1, 32'sd0, rpn_pkg::ST_UNDER, 1);
        add_row(rpn_pkg::OP_PUSH, 32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF, rpn_pkg::ST_OK, 2);
        add_row(rpn_pkg::OP_ADD,  32'sd0, 1'b1, 32'sh7FFFFFFF, rpn_pkg::ST_SAT, 1);
        add_row(rpn_pkg::OP_PUSH, 32'sh80000000, 1'b1, 32'sh80000000, rpn_pkg::ST_OK, 2);
        add_row(rpn_pkg::OP_SUB,  32'sd0, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(rpn_pkg::OP_PUSH, 32'sd0, 1'b1, 32'sd0, rpn_pkg::ST_OK, 2);
        add_row(rpn_pkg::OP_DIV,  32'sd0, 1'b1, 32'sd0, rpn_pkg::ST_DIVZ, 0);
        add_row(rpn_pkg::OP_PUSH, 32'sh00030000, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(rpn_pkg::OP_PUSH, -32'sh00018000, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(rpn_pkg::OP_MUL,  32'sd0, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(rpn_pkg::OP_PUSH, 32'sh00020000, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(rpn_pkg::OP_DIV,  32'sd0, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(rpn_pkg::OP_PUSH, 32'sh80000000, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(rpn_pkg::OP_MUL,  32'sd0, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(OpSpare6,         32'sh12345678, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(OpSpare7,         -32'sd1, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(rpn_pkg::OP_POP,  32'sd0, 1'b0, 32'sd0, rpn_pkg::ST_OK, 0);
        add_row(rpn_pkg::OP_POP,  32'sd0, 1'b1, rpn_pkg::MinusOneQ, rpn_pkg::ST_UNDER, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 79;
        foreach (dir_table[i])
        begin
            w.opcode = dir_table[i].opcode;
            w.operand = dir_table[i].operand;
            send_word(w, dir_table[i].check_exp, dir_table[i].exp_word);
        end

        // Fill to the top and try one more push to hit the full case.
        for (int i = calc_height; i <= rpn_pkg::StackDepth; i++)
        begin
            w.opcode = rpn_pkg::OP_PUSH;
            w.operand = rand_value();
            send_word(w, 1'b0, '0);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 19 : 0;
            for (n = 0; n < 220; n++)
            begin
                w.operand = rand_value();
                if ($urandom_range(99) < 3)
                    w.opcode = 3'($urandom_range(7));
                else if (calc_height < 2 || $urandom_range(99) < 40)
                    w.opcode = ($urandom_range(9) == 0) ? rpn_pkg::OP_POP : rpn_pkg::OP_PUSH;
                else
                    w.opcode = 3'($urandom_range(rpn_pkg::OP_DIV, rpn_pkg::OP_POP));
                // Divides are slow; keep them to a modest share.
                if (w.opcode == rpn_pkg::OP_DIV && $urandom_range(2) != 0)
                    w.opcode = rpn_pkg::OP_MUL;
                send_word(w, 1'b0, '0);
                if (n == 100)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (result_queue.size() != 0)
                        @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (result_queue.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("ran %0d result words: push %0d pop %0d add %0d sub %0d mul %0d div %0d",
                 result_count, op_count[0], op_count[1], op_count[2], op_count[3],
                 op_count[4], op_count[5]);
        $display("covered empty, full, saturation, divide by zero and unknown opcodes");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("timeout waiting for results");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/rpn_pkg.sv
rtl/rpn_divider.sv
rtl/rpn_stack_ram.sv
rtl/rpn_stack_calculator_core.sv
tb/tb_rpn_stack_calculator_core.sv
